[hw/rtl/vrn_pkg.sv]
// Shared types and constants for the vector reflection pipeline.
`timescale 1ns / 1ps
package vrn_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned WIDE_W  = 64;
    localparam int unsigned NUM_W   = 96;
    localparam int unsigned QBITS   = 33;
    localparam int unsigned REM_W   = 63;
    localparam int unsigned DIV_LAT = QBITS + 1;

    // Sideband that rides alongside the divider
    typedef struct packed {
        logic signed [WORD_W-1:0] vx;
        logic signed [WORD_W-1:0] vy;
        logic                     degen;
        logic                     negx;
        logic                     negy;
    } t_side;

endpackage

[hw/rtl/vrn_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module vrn_divider
    import vrn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_ce,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [WIDE_W-1:0]   i_den,
    output logic [QBITS-1:0]    o_quot
);

    logic [REM_W-1:0]  r_rem [0:QBITS];
    logic [QBITS-1:0]  r_low [0:QBITS];
    logic [QBITS-1:0]  r_q   [0:QBITS];
    logic [WIDE_W-1:0] r_den [0:QBITS];

    // quotient is known to fit QBITS bits, so the top part is already below den
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= i_num[NUM_W-1:QBITS];
            r_low[0] <= i_num[QBITS-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QBITS; k++) begin : g_stage
            logic [WIDE_W-1:0] n_trial;
            logic              n_fit;
            assign n_trial = {r_rem[k-1], r_low[k-1][QBITS-1]};
            assign n_fit   = (n_trial >= r_den[k-1]);
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k] <= n_fit ? REM_W'(n_trial - r_den[k-1]) : REM_W'(n_trial);
                    r_low[k] <= {r_low[k-1][QBITS-2:0], 1'b0};
                    r_q[k]   <= {r_q[k-1][QBITS-2:0], n_fit};
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    endgenerate

    assign o_quot = r_q[QBITS];

endmodule

[hw/rtl/vector_reflect_off_normal.sv]
// Top level: reflect a 2D fixed point vector off a normal, fully pipelined.
//
//  channel  dir  handshake                        payload
//  s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata: vec_x, vec_y, norm_x, norm_y
//  m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata: refl_x, refl_y; tuser: degen, sat
//  cfg      in   i_cfg_we                         i_cfg_wdata: epsilon
//
// One item per cycle while the output is not stalled; most of the pipeline is the 33-stage quotient divider.
// All stages advance together whenever the output register is empty or being taken.
// Reset clears valid bits and sets epsilon to 7.
`timescale 1ns / 1ps
module vector_reflect_off_normal
    import vrn_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // vec_x, vec_y, norm_x, norm_y
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata,   // refl_x, refl_y
    output logic [1:0]   o_m_axis_tuser,   // degenerate, saturated
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);

    localparam int unsigned PRE = 5;

    logic        ce;
    logic [31:0] r_eps_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps_sq <= 32'd49;
        end else if (i_cfg_we) begin
            r_eps_sq <= 32'(i_cfg_wdata) * 32'(i_cfg_wdata);
        end
    end

    logic r_vld_out;
    assign ce              = ~r_vld_out | i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // stage 1: products
    logic signed [31:0] in_vx, in_vy, in_nx, in_ny;
    assign in_vx = i_s_axis_tdata[31:0];
    assign in_vy = i_s_axis_tdata[63:32];
    assign in_nx = i_s_axis_tdata[95:64];
    assign in_ny = i_s_axis_tdata[127:96];

    logic signed [63:0] r1_nxx, r1_nyy, r1_vnx, r1_vny;
    logic signed [31:0] r1_vx, r1_vy, r1_nx, r1_ny;
    logic [63:0]        r2_m, r2_d;
    logic signed [31:0] r2_vx, r2_vy, r2_nx, r2_ny;
    logic [63:0]        r3_m, r3_dmag;
    logic [31:0]        r3_cx, r3_cy;
    t_side              r3_side;
    logic [63:0]        r4_m, r4_plx, r4_phx, r4_ply, r4_phy;
    t_side              r4_side;
    logic [95:0]        r5_numx, r5_numy;
    logic [63:0]        r5_m;
    t_side              r5_side;
    logic [PRE-1:0]     r_vld_pre;

    logic [63:0] n2_d;
    logic        n2_dneg;
    assign n2_d    = r2_d;
    assign n2_dneg = n2_d > 64'h8000_0000_0000_0000;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_nxx <= in_nx * in_nx;
            r1_nyy <= in_ny * in_ny;
            r1_vnx <= in_vx * in_nx;
            r1_vny <= in_vy * in_ny;
            r1_vx  <= in_vx;
            r1_vy  <= in_vy;
            r1_nx  <= in_nx;
            r1_ny  <= in_ny;

            r2_m  <= 64'(r1_nxx) + 64'(r1_nyy);
            r2_d  <= 64'(r1_vnx) + 64'(r1_vny);
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
            r2_nx <= r1_nx;
            r2_ny <= r1_ny;

            r3_m          <= r2_m;
            r3_dmag       <= n2_dneg ? 64'(64'd0 - n2_d) : n2_d;
            r3_cx         <= r2_nx[31] ? 32'(-r2_nx) : 32'(r2_nx);
            r3_cy         <= r2_ny[31] ? 32'(-r2_ny) : 32'(r2_ny);
            r3_side.vx    <= r2_vx;
            r3_side.vy    <= r2_vy;
            r3_side.degen <= r2_m <= {32'd0, r_eps_sq};
            r3_side.negx  <= n2_dneg ^ r2_nx[31];
            r3_side.negy  <= n2_dneg ^ r2_ny[31];

            // split the 64x32 product into two 32x32 halves
            r4_plx  <= r3_dmag[31:0]  * r3_cx;
            r4_phx  <= r3_dmag[63:32] * r3_cx;
            r4_ply  <= r3_dmag[31:0]  * r3_cy;
            r4_phy  <= r3_dmag[63:32] * r3_cy;
            r4_m    <= r3_m;
            r4_side <= r3_side;

            r5_numx <= {32'd0, r4_plx} + {r4_phx, 32'd0};
            r5_numy <= {32'd0, r4_ply} + {r4_phy, 32'd0};
            r5_m    <= r4_m;
            r5_side <= r4_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pre <= '0;
        end else if (ce) begin
            r_vld_pre <= {r_vld_pre[PRE-2:0], i_s_axis_tvalid};
        end
    end

    logic [QBITS-1:0] qx, qy;

    vrn_divider u_div_x (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_num  (r5_numx),
        .i_den  (r5_m),
        .o_quot (qx)
    );

    vrn_divider u_div_y (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_num  (r5_numy),
        .i_den  (r5_m),
        .o_quot (qy)
    );

    // sideband and valid delay matching the divider
    t_side              r_side [0:DIV_LAT-1];
    logic [DIV_LAT-1:0] r_vld_div;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= r5_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_div <= '0;
        end else if (ce) begin
            r_vld_div <= {r_vld_div[DIV_LAT-2:0], r_vld_pre[PRE-1]};
        end
    end

    // signed projection, then v - 2p (v itself when degenerate)
    t_side              sd;
    logic signed [33:0] n_px, n_py;
    assign sd   = r_side[DIV_LAT-1];
    assign n_px = sd.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign n_py = sd.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    logic signed [34:0] r6_dx, r6_dy;
    logic               r6_degen, r6_vld;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r6_dx    <= sd.degen ? 35'(sd.vx) : 35'(sd.vx) - 35'({n_px, 1'b0});
            r6_dy    <= sd.degen ? 35'(sd.vy) : 35'(sd.vy) - 35'({n_py, 1'b0});
            r6_degen <= sd.degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (ce) begin
            r6_vld <= r_vld_div[DIV_LAT-1];
        end
    end

    // clip to 32 bits
    logic        ovx, ovy;
    logic [31:0] n_rx, n_ry;
    assign ovx  = (r6_dx[34:31] != 4'b0000) && (r6_dx[34:31] != 4'b1111);
    assign ovy  = (r6_dy[34:31] != 4'b0000) && (r6_dy[34:31] != 4'b1111);
    assign n_rx = ovx ? (r6_dx[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r6_dx[31:0];
    assign n_ry = ovy ? (r6_dy[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r6_dy[31:0];

    logic [63:0] r_tdata;
    logic [1:0]  r_tuser;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_tdata <= {n_ry, n_rx};
            r_tuser <= {ovx | ovy, r6_degen};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= 1'b0;
        end else if (ce) begin
            r_vld_out <= r6_vld;
        end
    end

    assign o_m_axis_tvalid = r_vld_out;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_tuser;

endmodule
